@@ hdl/lcmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcmt_pkg
// shared widths, register codes, motion codes and control structs for the
// load cell motion tracking and tare scaler
// ----------------------------------------------------------------------------
package lcmt_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MSUM_W      = SAMPLE_BITS + 2;
    localparam int WSUM_W      = SAMPLE_BITS + 1;
    localparam int DIFF_W      = SAMPLE_BITS + 3;
    localparam int SCALE_W     = 24;
    localparam int GRAM_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int WEIGHT_W    = 32;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int MODE_W      = 2;

    localparam int PROD_W = DIFF_W + SCALE_W;
    localparam int DB_W   = GRAM_W + 24;
    localparam int CMP_W  = (PROD_W > DB_W) ? PROD_W : DB_W;
    localparam int Q_W    = PROD_W + 1 - 16;
    localparam int SAT_W  = (Q_W > 33) ? Q_W : 33;
    localparam int DCMP_W = (DIFF_W > CFG_DATA_W) ? DIFF_W : CFG_DATA_W;

    localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(32768);
    localparam logic [SAT_W-1:0]   NEG_LIMIT  = SAT_W'(64'h8000_0000);
    localparam logic [SAT_W-1:0]   POS_LIMIT  = SAT_W'(64'h7FFF_FFFF);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    // motion codes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STABLE = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_LIMIT        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TICKS        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_TARE_TICKS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BAND           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_TARE_MAX_GRAMS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAIN_SCALE          = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WASTE_SCALE         = 3'd6;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_MOTION_LIMIT        = 24'd1500;
    localparam logic [COUNT_W-1:0]    RST_STABLE_TICKS        = 16'd30;
    localparam logic [COUNT_W-1:0]    RST_AUTO_TARE_TICKS     = 16'd1800;
    localparam logic [GRAM_W-1:0]     RST_ZERO_BAND           = 16'd30;
    localparam logic [GRAM_W-1:0]     RST_AUTO_TARE_MAX_GRAMS = 16'd500;
    localparam logic [SCALE_W-1:0]    RST_MAIN_SCALE          = 24'd174751;
    localparam logic [SCALE_W-1:0]    RST_WASTE_SCALE         = 24'd111837;

    typedef logic signed [SAMPLE_BITS-1:0] cell_t;
    typedef logic signed [MSUM_W-1:0]      msum_t;
    typedef logic signed [WSUM_W-1:0]      wsum_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [WEIGHT_W-1:0]    weight_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] motion_limit;
        logic [COUNT_W-1:0]    stable_ticks;
        logic [COUNT_W-1:0]    auto_tare_ticks;
        logic [GRAM_W-1:0]     zero_band;
        logic [GRAM_W-1:0]     auto_tare_max_grams;
        logic [SCALE_W-1:0]    main_scale;
        logic [SCALE_W-1:0]    waste_scale;
    } cfg_t;

    typedef struct packed {
        logic                moved;
        logic                rezero;
        logic [MODE_W-1:0]   mode;
        logic [COUNT_W-1:0]  quiet_count;
        logic [COUNT_W-1:0]  idle_count;
    } motion_t;

endpackage
`default_nettype wire

@@ hdl/lcmt_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcmt_cfg_regs
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module lcmt_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [lcmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lcmt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lcmt_pkg::cfg_t                         cfg
);

    lcmt_pkg::cfg_t cfg_reg;
    lcmt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lcmt_pkg::REG_MOTION_LIMIT:
                    cfg_next.motion_limit = cfg_data;
                lcmt_pkg::REG_STABLE_TICKS:
                    cfg_next.stable_ticks = cfg_data[lcmt_pkg::COUNT_W-1:0];
                lcmt_pkg::REG_AUTO_TARE_TICKS:
                    cfg_next.auto_tare_ticks = cfg_data[lcmt_pkg::COUNT_W-1:0];
                lcmt_pkg::REG_ZERO_BAND:
                    cfg_next.zero_band = cfg_data[lcmt_pkg::GRAM_W-1:0];
                lcmt_pkg::REG_AUTO_TARE_MAX_GRAMS:
                    cfg_next.auto_tare_max_grams = cfg_data[lcmt_pkg::GRAM_W-1:0];
                lcmt_pkg::REG_MAIN_SCALE:
                    cfg_next.main_scale = cfg_data[lcmt_pkg::SCALE_W-1:0];
                lcmt_pkg::REG_WASTE_SCALE:
                    cfg_next.waste_scale = cfg_data[lcmt_pkg::SCALE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motion_limit        <= lcmt_pkg::RST_MOTION_LIMIT;
            cfg_reg.stable_ticks        <= lcmt_pkg::RST_STABLE_TICKS;
            cfg_reg.auto_tare_ticks     <= lcmt_pkg::RST_AUTO_TARE_TICKS;
            cfg_reg.zero_band           <= lcmt_pkg::RST_ZERO_BAND;
            cfg_reg.auto_tare_max_grams <= lcmt_pkg::RST_AUTO_TARE_MAX_GRAMS;
            cfg_reg.main_scale          <= lcmt_pkg::RST_MAIN_SCALE;
            cfg_reg.waste_scale         <= lcmt_pkg::RST_WASTE_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ hdl/lcmt_motion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcmt_motion
// motion detect, quiet and idle counters, auto re-zero decision
// ----------------------------------------------------------------------------
module lcmt_motion
(
    input  wire lcmt_pkg::msum_t               msum,
    input  wire lcmt_pkg::msum_t               last_main_sum,
    input  wire logic [lcmt_pkg::MODE_W-1:0]   mode,
    input  wire logic [lcmt_pkg::COUNT_W-1:0]  quiet_count,
    input  wire logic [lcmt_pkg::COUNT_W-1:0]  idle_count,
    input  wire lcmt_pkg::weight_t             main_grams,
    input  wire lcmt_pkg::cfg_t                cfg,
    output lcmt_pkg::motion_t                  motion
);

    lcmt_pkg::diff_t                   d;
    logic [lcmt_pkg::DIFF_W-1:0]       delta;
    logic [lcmt_pkg::COUNT_W-1:0]      quiet_inc;
    logic [lcmt_pkg::COUNT_W-1:0]      idle_inc;
    lcmt_pkg::weight_t                 tare_limit;
    logic                              below_limit;

    always_comb
    begin
        d     = lcmt_pkg::DIFF_W'(msum) - lcmt_pkg::DIFF_W'(last_main_sum);
        delta = d[lcmt_pkg::DIFF_W-1] ? lcmt_pkg::DIFF_W'(-d) : lcmt_pkg::DIFF_W'(d);

        quiet_inc = (quiet_count == lcmt_pkg::COUNT_MAX) ? quiet_count
                                                         : quiet_count + 1'b1;
        idle_inc  = (idle_count == lcmt_pkg::COUNT_MAX) ? idle_count
                                                        : idle_count + 1'b1;

        // grams limit in q8, never negative
        tare_limit  = $signed({8'd0, cfg.auto_tare_max_grams, 8'd0});
        below_limit = main_grams < tare_limit;

        motion.moved       = lcmt_pkg::DCMP_W'(delta)
                             > lcmt_pkg::DCMP_W'(cfg.motion_limit);
        motion.rezero      = 1'b0;
        motion.mode        = mode;
        motion.quiet_count = quiet_count;
        motion.idle_count  = idle_count;

        if (motion.moved)
        begin
            motion.mode        = lcmt_pkg::MODE_MOVING;
            motion.quiet_count = '0;
            motion.idle_count  = '0;
        end
        else if (mode == lcmt_pkg::MODE_MOVING)
        begin
            motion.quiet_count = quiet_inc;
            if (quiet_inc >= cfg.stable_ticks)
            begin
                motion.mode = lcmt_pkg::MODE_STABLE;
            end
        end
        else
        begin
            motion.mode       = lcmt_pkg::MODE_IDLE;
            motion.idle_count = idle_inc;
            if ((idle_inc >= cfg.auto_tare_ticks) && below_limit)
            begin
                motion.rezero     = 1'b1;
                motion.idle_count = '0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/lcmt_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcmt_scale
// signed counts to q8 grams: magnitude times q0.24 scale, deadband,
// round half away from zero, saturate to 32 bits
// ----------------------------------------------------------------------------
module lcmt_scale
(
    input  wire lcmt_pkg::diff_t               diff,
    input  wire logic [lcmt_pkg::SCALE_W-1:0]  scale,
    input  wire logic [lcmt_pkg::GRAM_W-1:0]   deadband,
    output lcmt_pkg::weight_t                  grams
);

    logic                           neg;
    logic [lcmt_pkg::DIFF_W-1:0]    mag;
    logic [lcmt_pkg::PROD_W-1:0]    prod;
    logic [lcmt_pkg::DB_W-1:0]      db_q24;
    logic                           in_deadband;
    logic [lcmt_pkg::PROD_W:0]      rnd;
    logic [lcmt_pkg::SAT_W-1:0]     qx;
    logic [lcmt_pkg::SAT_W-1:0]     qs;

    always_comb
    begin
        neg  = diff[lcmt_pkg::DIFF_W-1];
        mag  = neg ? lcmt_pkg::DIFF_W'(-diff) : lcmt_pkg::DIFF_W'(diff);
        prod = lcmt_pkg::PROD_W'(mag) * lcmt_pkg::PROD_W'(scale);

        db_q24      = {deadband, 24'd0};
        in_deadband = lcmt_pkg::CMP_W'(prod) < lcmt_pkg::CMP_W'(db_q24);

        rnd = (lcmt_pkg::PROD_W + 1)'(prod) + lcmt_pkg::ROUND_HALF;
        qx  = lcmt_pkg::SAT_W'(rnd[lcmt_pkg::PROD_W:16]);

        if (neg)
        begin
            qs = (qx > lcmt_pkg::NEG_LIMIT) ? lcmt_pkg::NEG_LIMIT : qx;
        end
        else
        begin
            qs = (qx > lcmt_pkg::POS_LIMIT) ? lcmt_pkg::POS_LIMIT : qx;
        end

        if (in_deadband)
        begin
            grams = '0;
        end
        else if (neg)
        begin
            grams = lcmt_pkg::WEIGHT_W'(lcmt_pkg::SAT_W'(0) - qs);
        end
        else
        begin
            grams = lcmt_pkg::WEIGHT_W'(qs);
        end
    end

endmodule
`default_nettype wire

@@ hdl/load_cell_motion_tare_scaler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// load_cell_motion_tare_scaler_top
// sums main and waste cells, tracks motion and auto-zero, applies tare and
// scales both loads to q8 grams
//
//   channel   handshake                   payload
//   sample    sample_valid / sample_stall action, waste_cell_0..1, main_cell_0..3
//   result    result_valid / result_stall main_weight, waste_weight, motion_state
//   config    cfg_write                   cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; a sample transfer
// loads the input register, then one pass of adders and the two 27x24
// multipliers feeds the state registers that also drive the result
// reset clears all state and the sums and bases at once
// the input register takes one item while a result waits under stall
// ----------------------------------------------------------------------------
module load_cell_motion_tare_scaler_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire logic                              action,
    input  wire lcmt_pkg::cell_t                   waste_cell_0,
    input  wire lcmt_pkg::cell_t                   waste_cell_1,
    input  wire lcmt_pkg::cell_t                   main_cell_0,
    input  wire lcmt_pkg::cell_t                   main_cell_1,
    input  wire lcmt_pkg::cell_t                   main_cell_2,
    input  wire lcmt_pkg::cell_t                   main_cell_3,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output lcmt_pkg::weight_t                      main_weight,
    output lcmt_pkg::weight_t                      waste_weight,
    output logic [lcmt_pkg::MODE_W-1:0]            motion_state,
    input  wire logic                              cfg_write,
    input  wire logic [lcmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [lcmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lcmt_pkg::cfg_t     cfg;
    lcmt_pkg::motion_t  motion;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               action_reg;
    lcmt_pkg::cell_t    waste_cell_0_reg;
    lcmt_pkg::cell_t    waste_cell_1_reg;
    lcmt_pkg::cell_t    main_cell_0_reg;
    lcmt_pkg::cell_t    main_cell_1_reg;
    lcmt_pkg::cell_t    main_cell_2_reg;
    lcmt_pkg::cell_t    main_cell_3_reg;

    // state, which also forms the result register
    logic                           result_valid_reg;
    logic                           result_valid_next;
    lcmt_pkg::msum_t                last_main_sum_reg;
    lcmt_pkg::msum_t                last_main_sum_next;
    lcmt_pkg::wsum_t                last_waste_sum_reg;
    lcmt_pkg::wsum_t                last_waste_sum_next;
    lcmt_pkg::msum_t                main_base_reg;
    lcmt_pkg::msum_t                main_base_next;
    lcmt_pkg::wsum_t                waste_base_reg;
    lcmt_pkg::wsum_t                waste_base_next;
    logic [lcmt_pkg::MODE_W-1:0]    mode_reg;
    logic [lcmt_pkg::MODE_W-1:0]    mode_next;
    logic [lcmt_pkg::COUNT_W-1:0]   quiet_count_reg;
    logic [lcmt_pkg::COUNT_W-1:0]   quiet_count_next;
    logic [lcmt_pkg::COUNT_W-1:0]   idle_count_reg;
    logic [lcmt_pkg::COUNT_W-1:0]   idle_count_next;
    lcmt_pkg::weight_t              main_grams_reg;
    lcmt_pkg::weight_t              main_grams_next;
    lcmt_pkg::weight_t              waste_grams_reg;
    lcmt_pkg::weight_t              waste_grams_next;

    logic               in_xfer;
    logic               advance;
    lcmt_pkg::msum_t    msum;
    lcmt_pkg::wsum_t    wsum;
    lcmt_pkg::diff_t    main_diff;
    lcmt_pkg::diff_t    waste_diff;
    lcmt_pkg::weight_t  main_scaled;
    lcmt_pkg::weight_t  waste_scaled;

    lcmt_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcmt_motion u_motion
    (
        .msum          (msum),
        .last_main_sum (last_main_sum_reg),
        .mode          (mode_reg),
        .quiet_count   (quiet_count_reg),
        .idle_count    (idle_count_reg),
        .main_grams    (main_grams_reg),
        .cfg           (cfg),
        .motion        (motion)
    );

    lcmt_scale u_main_scale
    (
        .diff     (main_diff),
        .scale    (cfg.main_scale),
        .deadband (cfg.zero_band),
        .grams    (main_scaled)
    );

    lcmt_scale u_waste_scale
    (
        .diff     (waste_diff),
        .scale    (cfg.waste_scale),
        .deadband (cfg.zero_band),
        .grams    (waste_scaled)
    );

    assign advance      = in_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign in_xfer      = sample_valid && !sample_stall;

    always_comb
    begin
        msum = lcmt_pkg::MSUM_W'(main_cell_0_reg) + lcmt_pkg::MSUM_W'(main_cell_1_reg)
             + lcmt_pkg::MSUM_W'(main_cell_2_reg) + lcmt_pkg::MSUM_W'(main_cell_3_reg);
        wsum = lcmt_pkg::WSUM_W'(waste_cell_0_reg) + lcmt_pkg::WSUM_W'(waste_cell_1_reg);

        main_diff  = lcmt_pkg::DIFF_W'(msum) - lcmt_pkg::DIFF_W'(main_base_reg);
        waste_diff = lcmt_pkg::DIFF_W'(wsum) - lcmt_pkg::DIFF_W'(waste_base_reg);

        in_valid_next       = in_valid_reg;
        result_valid_next   = result_valid_reg;
        last_main_sum_next  = last_main_sum_reg;
        last_waste_sum_next = last_waste_sum_reg;
        main_base_next      = main_base_reg;
        waste_base_next     = waste_base_reg;
        mode_next           = mode_reg;
        quiet_count_next    = quiet_count_reg;
        idle_count_next     = idle_count_reg;
        main_grams_next     = main_grams_reg;
        waste_grams_next    = waste_grams_reg;

        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (advance)
        begin
            if (action_reg)
            begin
                // tare: weights and mode repeat until the next sample
                main_base_next  = last_main_sum_reg;
                waste_base_next = last_waste_sum_reg;
            end
            else
            begin
                last_main_sum_next  = msum;
                last_waste_sum_next = wsum;
                mode_next           = motion.mode;
                quiet_count_next    = motion.quiet_count;
                idle_count_next     = motion.idle_count;
                main_grams_next     = main_scaled;
                waste_grams_next    = waste_scaled;
                // a re-zero makes the main base equal to this sum
                if (motion.rezero)
                begin
                    main_base_next  = msum;
                    main_grams_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            result_valid_reg   <= 1'b0;
            last_main_sum_reg  <= '0;
            last_waste_sum_reg <= '0;
            main_base_reg      <= '0;
            waste_base_reg     <= '0;
            mode_reg           <= lcmt_pkg::MODE_IDLE;
            quiet_count_reg    <= '0;
            idle_count_reg     <= '0;
            main_grams_reg     <= '0;
            waste_grams_reg    <= '0;
        end
        else
        begin
            in_valid_reg       <= in_valid_next;
            result_valid_reg   <= result_valid_next;
            last_main_sum_reg  <= last_main_sum_next;
            last_waste_sum_reg <= last_waste_sum_next;
            main_base_reg      <= main_base_next;
            waste_base_reg     <= waste_base_next;
            mode_reg           <= mode_next;
            quiet_count_reg    <= quiet_count_next;
            idle_count_reg     <= idle_count_next;
            main_grams_reg     <= main_grams_next;
            waste_grams_reg    <= waste_grams_next;
        end
    end

    // input payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg       <= action;
            waste_cell_0_reg <= waste_cell_0;
            waste_cell_1_reg <= waste_cell_1;
            main_cell_0_reg  <= main_cell_0;
            main_cell_1_reg  <= main_cell_1;
            main_cell_2_reg  <= main_cell_2;
            main_cell_3_reg  <= main_cell_3;
        end
    end

    assign result_valid = result_valid_reg;
    assign main_weight  = main_grams_reg;
    assign waste_weight = waste_grams_reg;
    assign motion_state = mode_reg;

    // an empty result side never holds off the input
    a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> !sample_stall)
        else $error("input stalled while result register empty");

    // a tare transfer leaves weights and mode untouched
    a_tare_holds_result : assert property (@(posedge clk) disable iff (!rst_n)
        advance && action_reg |=>
            $stable(main_weight) && $stable(waste_weight) && $stable(motion_state))
        else $error("tare changed the reported result");

    // motion clears both counters and enters moving
    a_motion_clears : assert property (@(posedge clk) disable iff (!rst_n)
        advance && !action_reg && motion.moved |=>
            (mode_reg == lcmt_pkg::MODE_MOVING) && (quiet_count_reg == '0)
            && (idle_count_reg == '0))
        else $error("motion did not reset counters");

    // a sample that re-zeroes reports a main weight of zero
    a_rezero_zero_weight : assert property (@(posedge clk) disable iff (!rst_n)
        advance && !action_reg && motion.rezero |=> (main_weight == '0))
        else $error("re-zero left a nonzero main weight");

endmodule
`default_nettype wire
